// File: sv/pal_pkg.sv
package pal_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int ENTRY_BITS  = 8;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CMD_W       = 3;
    localparam int POS_W       = 6;
    localparam int STATUS_W    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 3'd0,
        CMD_REMOVE   = 3'd1,
        CMD_RETRIEVE = 3'd2,
        CMD_REPLACE  = 3'd3,
        CMD_CLEAR    = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_REPLACE
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [IDX_W-1:0]      pos;
        logic [ENTRY_BITS-1:0] val;
    } t_cell_ctl;

endpackage

// File: sv/pal_cell.sv
module pal_cell (
    input  logic                           i_clk,
    input  logic [pal_pkg::IDX_W-1:0]      i_idx,
    input  pal_pkg::t_cell_ctl             i_ctl,
    input  logic [pal_pkg::ENTRY_BITS-1:0] i_lower,
    input  logic [pal_pkg::ENTRY_BITS-1:0] i_upper,
    output logic [pal_pkg::ENTRY_BITS-1:0] o_q
);
    import pal_pkg::*;

    logic [ENTRY_BITS-1:0] r_q;
    logic [ENTRY_BITS-1:0] n_q;

    always_comb begin
        n_q = r_q;
        unique case (i_ctl.op)
            CELL_INSERT: begin
                // open a gap at the position, take the lower neighbor above it
                if (i_idx == i_ctl.pos) begin
                    n_q = i_ctl.val;
                end else if (i_idx > i_ctl.pos) begin
                    n_q = i_lower;
                end
            end
            CELL_REMOVE: begin
                // close the gap: pull the upper neighbor down
                if (i_idx >= i_ctl.pos) begin
                    n_q = i_upper;
                end
            end
            CELL_REPLACE: begin
                if (i_idx == i_ctl.pos) begin
                    n_q = i_ctl.val;
                end
            end
            default: n_q = r_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

// File: sv/pal_ctrl.sv
module pal_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pal_pkg::CMD_W-1:0]      i_cmd,
    input  logic [pal_pkg::POS_W-1:0]      i_position,
    input  logic [pal_pkg::ENTRY_BITS-1:0] i_item_in,
    input  logic [pal_pkg::ENTRY_BITS-1:0] i_rd_data,
    output logic [pal_pkg::IDX_W-1:0]      o_rd_idx,
    output pal_pkg::t_cell_ctl             o_ctl,
    output logic                           o_busy,
    output logic                           o_valid,
    output logic [pal_pkg::STATUS_W-1:0]   o_status,
    output logic [pal_pkg::ENTRY_BITS-1:0] o_item_out,
    output logic [pal_pkg::CNT_W-1:0]      o_length
);
    import pal_pkg::*;

    logic                  r_ready;
    logic                  r_valid;
    logic [CNT_W-1:0]      r_used;
    logic [CNT_W-1:0]      n_used;
    t_status               r_status;
    t_status               n_status;
    logic [ENTRY_BITS-1:0] r_item;
    logic [ENTRY_BITS-1:0] n_item;
    t_cell_op              n_op;
    logic                  accept;
    logic                  neg;
    logic [CNT_W-1:0]      pos;
    logic                  full;
    logic                  empty;

    assign accept = i_start && r_ready;
    assign neg    = i_position[POS_W-1];
    assign pos    = i_position[CNT_W-1:0];
    assign full   = (r_used == CNT_W'(MAX_ENTRIES));
    assign empty  = (r_used == '0);

    always_comb begin
        n_used   = r_used;
        n_status = ST_OK;
        n_item   = '0;
        n_op     = CELL_HOLD;
        if (accept) begin
            unique case (i_cmd)
                CMD_INSERT: begin
                    if (full) begin
                        n_status = ST_OVERFLOW;
                    end else if (neg || pos > r_used) begin
                        n_status = ST_RANGE;
                    end else begin
                        n_op   = CELL_INSERT;
                        n_used = r_used + 1'b1;
                    end
                end
                CMD_REMOVE, CMD_RETRIEVE, CMD_REPLACE: begin
                    if (empty) begin
                        n_status = ST_UNDERFLOW;
                    end else if (neg || pos >= r_used) begin
                        n_status = ST_RANGE;
                    end else if (i_cmd == CMD_REPLACE) begin
                        n_op = CELL_REPLACE;
                    end else begin
                        n_item = i_rd_data;
                        if (i_cmd == CMD_REMOVE) begin
                            n_op   = CELL_REMOVE;
                            n_used = r_used - 1'b1;
                        end
                    end
                end
                CMD_CLEAR: n_used = '0;
                default:   n_used = r_used;
            endcase
        end
    end

    assign o_rd_idx  = pos[IDX_W-1:0];
    assign o_ctl.op  = n_op;
    assign o_ctl.pos = pos[IDX_W-1:0];
    assign o_ctl.val = i_item_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_valid <= 1'b0;
            r_used  <= '0;
        end else begin
            r_ready <= 1'b1;
            r_valid <= accept;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_item   <= n_item;
    end

    assign o_busy     = !r_ready;
    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_item_out = r_item;
    assign o_length   = r_used;

    a_beat_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_valid)
        else $error("accepted beat gave no result");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above capacity");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == ST_OVERFLOW) |-> full)
        else $error("overflow reported on a list that is not full");

    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == ST_UNDERFLOW) |-> empty)
        else $error("underflow reported on a list that is not empty");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!accept) |=> $stable(r_used))
        else $error("entry count moved without a beat");

endmodule

// File: sv/positional_array_list.sv
// Bounded ordered list of up to 16 eight-bit entries. Pulse i_start with a
// command (insert, remove, retrieve, replace, clear), a signed position and
// a value; one result follows in the next cycle on o_valid with status, the
// entry read and the new length. The result is shown for that single cycle
// and cannot be held off, so capture it then. Every entry sits in its own
// cell of a row that shifts all entries at once, so a new command can be
// issued in every cycle while o_busy is low. o_busy is high only while in
// reset and for the first cycle after it.
module positional_array_list (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pal_pkg::CMD_W-1:0]      i_cmd,
    input  logic [pal_pkg::POS_W-1:0]      i_position,
    input  logic [pal_pkg::ENTRY_BITS-1:0] i_item_in,
    output logic                           o_busy,
    output logic                           o_valid,
    output logic [pal_pkg::STATUS_W-1:0]   o_status,
    output logic [pal_pkg::ENTRY_BITS-1:0] o_item_out,
    output logic [pal_pkg::CNT_W-1:0]      o_length
);
    import pal_pkg::*;

    logic [ENTRY_BITS-1:0] cell_q [MAX_ENTRIES];
    logic [IDX_W-1:0]      rd_idx;
    logic [ENTRY_BITS-1:0] rd_data;
    t_cell_ctl             ctl;

    assign rd_data = cell_q[rd_idx];

    pal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_cmd      (i_cmd),
        .i_position (i_position),
        .i_item_in  (i_item_in),
        .i_rd_data  (rd_data),
        .o_rd_idx   (rd_idx),
        .o_ctl      (ctl),
        .o_busy     (o_busy),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_item_out (o_item_out),
        .o_length   (o_length)
    );

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic [ENTRY_BITS-1:0] lower;
        logic [ENTRY_BITS-1:0] upper;

        // ends of the row feed back their own entry
        if (g == 0) begin : g_lo_end
            assign lower = cell_q[g];
        end else begin : g_lo
            assign lower = cell_q[g-1];
        end
        if (g == MAX_ENTRIES - 1) begin : g_hi_end
            assign upper = cell_q[g];
        end else begin : g_hi
            assign upper = cell_q[g+1];
        end

        pal_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (IDX_W'(g)),
            .i_ctl   (ctl),
            .i_lower (lower),
            .i_upper (upper),
            .o_q     (cell_q[g])
        );
    end

endmodule
